// ===== rtl/hsv_region_color_classifier_macros.svh =====
// Assertion macros for the HSV region color classifier.
// Define ASSERT_OFF to compile the checks out.
`ifndef HSV_REGION_COLOR_CLASSIFIER_MACROS_SVH
`define HSV_REGION_COLOR_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define HRCC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrcc assertion failed");

// Next-cycle implication.
`define HRCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrcc assertion failed");

`else

`define HRCC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HRCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/hrcc_pkg.sv =====
package hrcc_pkg;

   localparam int MaxRegionPixels = 65536;
   localparam int CountWidth      = 17;
   localparam int RatioWidth      = 17;
   localparam int RatioShift      = 16;
   localparam int ProdWidth       = RatioWidth + CountWidth;
   localparam int NumBuckets      = 5;
   localparam int NumMainBounds   = 8;
   localparam int NumRedBounds    = 4;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 64;

   typedef logic [CountWidth-1:0] count_type;

   localparam count_type CountMax = count_type'(MaxRegionPixels);

   typedef enum logic [2:0] {
      ColorRed    = 3'd0,
      ColorOrange = 3'd1,
      ColorYellow = 3'd2,
      ColorGreen  = 3'd3,
      ColorBlue   = 3'd4,
      ColorWhite  = 3'd5
   } color_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrWhiteRatio    = 3'd0,
      CsrWhiteSatMax   = 3'd1,
      CsrWhiteValueMin = 3'd2,
      CsrColorValueMin = 3'd3,
      CsrHueBoundsMain = 3'd4,
      CsrHueBoundsRed  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      color_type color;
      count_type winning_count;
   } result_type;

   typedef struct packed {
      logic [RatioWidth-1:0]          white_ratio;
      logic [7:0]                     white_sat_max;
      logic [7:0]                     white_value_min;
      logic [7:0]                     color_value_min;
      logic [NumMainBounds-1:0][7:0]  hue_bounds_main;
      logic [NumRedBounds-1:0][7:0]   hue_bounds_red;
   } cfg_type;

   // per-pixel decisions, indexed by color code for bucket_hit
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  white;
      logic                  colored;
      logic [NumBuckets-1:0] bucket_hit;
   } pix_flags_type;

   typedef struct packed {
      count_type                  white_count;
      count_type                  colored_count;
      count_type [NumBuckets-1:0] bucket_counts;
   } region_counts_type;

   function automatic count_type sat_inc(count_type c, logic en);
      count_type r;
      r = c;
      if (en && (c != CountMax)) begin
         r = c + count_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/hsv_region_color_classifier.sv =====
// Channel   Direction  Ports                                   Transaction when
// -------   ---------  --------------------------------------  -------------------------
// pixel     in         start, busy, req_pixel                  start && !busy at clock
// result    out        rsp_strobe, rsp_result                  rsp_strobe high, 1 cycle
// csr       in         csr_write_en, csr_index, csr_write_data csr_write_en at clock
//
// One pixel per clock, every clock; busy is only raised while reset is high.
// A region's result strobes once its last pixel is taken and has passed the
// input register, classify, count, product/argmax and white test stages.
// The 17x17 ratio product is registered with the argmax, ahead of the final compare.
// Reset is synchronous: counters and valid flags clear, config registers go to defaults.
// The receiver cannot stall; every strobe is one delivered result.
module hsv_region_color_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hrcc_pkg::pixel_type                 req_pixel,
   output logic                                rsp_strobe,
   output hrcc_pkg::result_type                rsp_result,
   input  logic                                csr_write_en,
   input  logic [hrcc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [hrcc_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import hrcc_pkg::*;

   `include "hsv_region_color_classifier_macros.svh"

   // Configuration registers. Indexes beyond the list are dropped.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrWhiteRatio:    cfg_in.white_ratio     = csr_write_data[RatioWidth-1:0];
            CsrWhiteSatMax:   cfg_in.white_sat_max   = csr_write_data[7:0];
            CsrWhiteValueMin: cfg_in.white_value_min = csr_write_data[7:0];
            CsrColorValueMin: cfg_in.color_value_min = csr_write_data[7:0];
            CsrHueBoundsMain: cfg_in.hue_bounds_main = csr_write_data[8*NumMainBounds-1:0];
            CsrHueBoundsRed:  cfg_in.hue_bounds_red  = csr_write_data[8*NumRedBounds-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.white_ratio     <= RatioWidth'(32768);
         cfg_ff.white_sat_max   <= 8'd60;
         cfg_ff.white_value_min <= 8'd100;
         cfg_ff.color_value_min <= 8'd40;
         cfg_ff.hue_bounds_main <= '0;
         cfg_ff.hue_bounds_red  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: a pixel transaction lands here on the accepting edge.
   logic      accept;
   logic      pix_valid_ff;
   pixel_type pix_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= req_pixel;
   end

   // Pipeline
   pix_flags_type     flags;
   logic              snap_valid;
   region_counts_type snap;

   hrcc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid_ff),
      .pix       (pix_ff),
      .cfg       (cfg_ff),
      .flags     (flags)
   );

   hrcc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .flags      (flags),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   hrcc_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .white_ratio (cfg_ff.white_ratio),
      .res_valid   (rsp_strobe),
      .res         (rsp_result)
   );

   // A strobe always traces back to an accepted last pixel.
   `HRCC_ASSERT_IMPLIES(a_strobe_from_last, clock, reset, rsp_strobe, $past(start && !busy && req_pixel.last_pixel, 5))

   // White can only win with at least one white pixel.
   `HRCC_ASSERT_IMPLIES(a_white_nonzero, clock, reset, rsp_strobe && (rsp_result.color == ColorWhite), rsp_result.winning_count != '0)

   // Buckets only grow alongside the colored count.
   `HRCC_ASSERT_IMPLIES(a_buckets_le_colored, clock, reset, snap_valid, (snap.bucket_counts[0] <= snap.colored_count) && (snap.bucket_counts[1] <= snap.colored_count) && (snap.bucket_counts[2] <= snap.colored_count) && (snap.bucket_counts[3] <= snap.colored_count) && (snap.bucket_counts[4] <= snap.colored_count))

   // A closed region hands off exactly one snapshot per last pixel.
   `HRCC_ASSERT_NEXT(a_last_to_snap, clock, reset, flags.valid && flags.last, snap_valid)

endmodule

// ===== rtl/hrcc_classify.sv =====
module hrcc_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pix_valid,
   input  hrcc_pkg::pixel_type   pix,
   input  hrcc_pkg::cfg_type     cfg,
   output hrcc_pkg::pix_flags_type flags
);
   import hrcc_pkg::*;

   pix_flags_type flags_ff, flags_in;
   logic [7:0]    h;
   logic          is_orange, is_yellow, is_green, is_blue, is_red;

   assign h = pix.hue;

   always_comb begin
      is_orange = (h >= cfg.hue_bounds_main[0]) && (h <= cfg.hue_bounds_main[1]);
      is_yellow = (h >  cfg.hue_bounds_main[2]) && (h <= cfg.hue_bounds_main[3]);
      is_green  = (h >  cfg.hue_bounds_main[4]) && (h <= cfg.hue_bounds_main[5]);
      is_blue   = (h >  cfg.hue_bounds_main[6]) && (h <= cfg.hue_bounds_main[7]);
      is_red    = ((h >= cfg.hue_bounds_red[0]) && (h <= cfg.hue_bounds_red[1])) ||
                  ((h >= cfg.hue_bounds_red[2]) && (h <  cfg.hue_bounds_red[3]));

      flags_in         = '0;
      flags_in.valid   = pix_valid;
      flags_in.last    = pix.last_pixel;
      flags_in.white   = (pix.saturation <= cfg.white_sat_max) &&
                         (pix.brightness > cfg.white_value_min);
      flags_in.colored = pix.brightness > cfg.color_value_min;
      // first match wins: orange, yellow, green, blue, then red
      if (flags_in.colored) begin
         if (is_orange) begin
            flags_in.bucket_hit[ColorOrange] = 1'b1;
         end else if (is_yellow) begin
            flags_in.bucket_hit[ColorYellow] = 1'b1;
         end else if (is_green) begin
            flags_in.bucket_hit[ColorGreen] = 1'b1;
         end else if (is_blue) begin
            flags_in.bucket_hit[ColorBlue] = 1'b1;
         end else if (is_red) begin
            flags_in.bucket_hit[ColorRed] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

// ===== rtl/hrcc_accum.sv =====
module hrcc_accum (
   input  logic                       clock,
   input  logic                       reset,
   input  hrcc_pkg::pix_flags_type    flags,
   output logic                       snap_valid,
   output hrcc_pkg::region_counts_type snap
);
   import hrcc_pkg::*;

   region_counts_type cnt_ff, cnt_in;
   region_counts_type upd;
   region_counts_type snap_ff, snap_in;
   logic              snap_valid_ff, snap_valid_in;

   always_comb begin
      upd.white_count   = sat_inc(cnt_ff.white_count, flags.white);
      upd.colored_count = sat_inc(cnt_ff.colored_count, flags.colored);
      for (int i = 0; i < NumBuckets; i++) begin
         upd.bucket_counts[i] = sat_inc(cnt_ff.bucket_counts[i], flags.bucket_hit[i]);
      end

      cnt_in        = cnt_ff;
      snap_in       = snap_ff;
      snap_valid_in = 1'b0;
      if (flags.valid) begin
         if (flags.last) begin
            // region closes: hand off the totals, start the next region empty
            snap_in       = upd;
            snap_valid_in = 1'b1;
            cnt_in        = '0;
         end else begin
            cnt_in = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ===== rtl/hrcc_decide.sv =====
module hrcc_decide (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        snap_valid,
   input  hrcc_pkg::region_counts_type snap,
   input  logic [hrcc_pkg::RatioWidth-1:0] white_ratio,
   output logic                        res_valid,
   output hrcc_pkg::result_type        res
);
   import hrcc_pkg::*;

   // stage 1: product and bucket argmax
   logic [ProdWidth-1:0] prod_ff, prod_in;
   count_type            white_ff;
   color_type            best_color_ff, best_color_in;
   count_type            best_cnt_ff, best_cnt_in;
   logic                 s1_valid_ff;

   color_type c01, c23, c03;
   count_type n01, n23, n03;

   // stage 2: white test and output select
   logic [ProdWidth-1:0] lhs;
   logic                 white_wins;
   result_type           res_ff, res_in;
   logic                 res_valid_ff;

   // ties keep the lower color code
   always_comb begin
      prod_in = ProdWidth'(snap.colored_count) * ProdWidth'(white_ratio);

      if (snap.bucket_counts[ColorOrange] > snap.bucket_counts[ColorRed]) begin
         c01 = ColorOrange;
         n01 = snap.bucket_counts[ColorOrange];
      end else begin
         c01 = ColorRed;
         n01 = snap.bucket_counts[ColorRed];
      end
      if (snap.bucket_counts[ColorGreen] > snap.bucket_counts[ColorYellow]) begin
         c23 = ColorGreen;
         n23 = snap.bucket_counts[ColorGreen];
      end else begin
         c23 = ColorYellow;
         n23 = snap.bucket_counts[ColorYellow];
      end
      if (n23 > n01) begin
         c03 = c23;
         n03 = n23;
      end else begin
         c03 = c01;
         n03 = n01;
      end
      if (snap.bucket_counts[ColorBlue] > n03) begin
         best_color_in = ColorBlue;
         best_cnt_in   = snap.bucket_counts[ColorBlue];
      end else begin
         best_color_in = c03;
         best_cnt_in   = n03;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      white_ff      <= snap.white_count;
      best_color_ff <= best_color_in;
      best_cnt_ff   <= best_cnt_in;
   end

   always_comb begin
      lhs        = ProdWidth'(white_ff) << RatioShift;
      white_wins = lhs > prod_ff;
      if (white_wins) begin
         res_in.color         = ColorWhite;
         res_in.winning_count = white_ff;
      end else begin
         res_in.color         = best_color_ff;
         res_in.winning_count = best_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= snap_valid;
         res_valid_ff <= s1_valid_ff;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule
